// File: hdl/pwfe_pkg.sv
package pwfe_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_of_run;
        logic       frame_end;
    } t_out_item;

    localparam int unsigned STEP_W = 5;

    localparam logic [STEP_W-1:0] STEP_PREAMBLE = 5'd0;
    localparam logic [STEP_W-1:0] STEP_DATA     = 5'd6;
    localparam logic [STEP_W-1:0] STEP_DATA_END = 5'd13;
    localparam logic [STEP_W-1:0] STEP_PARITY   = 5'd14;
    localparam logic [STEP_W-1:0] STEP_TAIL     = 5'd15;
    localparam logic [STEP_W-1:0] STEP_STOP     = 5'd16;
    localparam logic [STEP_W-1:0] STEP_END      = 5'd20;

    localparam logic [7:0] PAT_ONE   = 8'hC0;
    localparam logic [7:0] PAT_ZERO  = 8'hFC;
    localparam logic [3:0] CARRY_RST = 4'hC;
    localparam logic [3:0] TAIL_NIB  = 4'hF;

    function automatic logic [7:0] preamble_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'h00;
            3'd1: b = 8'hFF;
            3'd2: b = 8'hFF;
            3'd3: b = 8'hFC;
            3'd4: b = 8'hFF;
            3'd5: b = 8'h83;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] stop_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'hFF;
            3'd1: b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/pulse_width_frame_encoder_top.sv
// the input item is registered first, then each line byte is built from it and registered before it is offered
// one line byte per cycle while the receiver does not stall; a middle byte gives one line byte per data bit,
// an opening byte adds the preamble, a closing byte adds parity, tail and stop bytes (step counter)
// the next input transfer is taken in the cycle the last line byte is registered
// reset: synchronous active-low, returns to idle outside a frame, carry nibble C
module pulse_width_frame_encoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pwfe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pwfe_pkg::t_out_item o_out_item
);

    logic                          r_busy;
    logic                          r_in_frame;
    logic [7:0]                    r_data;
    logic                          r_last;
    logic [pwfe_pkg::STEP_W-1:0]   r_step;
    logic [3:0]                    r_carry;
    logic                          r_parity;
    logic                          r_out_valid;
    pwfe_pkg::t_out_item           r_out;

    logic                          fire;
    logic                          at_end;
    logic                          final_fire;
    logic                          accept;
    logic                          open_new;
    logic [pwfe_pkg::STEP_W-1:0]   end_step;
    logic [7:0]                    pat;
    logic                          use_pat;
    logic                          bit_val;
    logic [7:0]                    n_byte;
    logic [3:0]                    n_carry;
    logic                          n_parity;

    assign end_step   = r_last ? pwfe_pkg::STEP_END : pwfe_pkg::STEP_DATA_END;
    assign at_end     = r_step == end_step;
    assign fire       = r_busy && (!r_out_valid || i_out_ready);
    assign final_fire = fire && at_end;
    assign o_in_ready = !r_busy || final_fire;
    assign accept     = i_in_valid && o_in_ready;
    assign open_new   = !r_in_frame || (final_fire && r_last);
    assign bit_val    = r_data[3'(pwfe_pkg::STEP_DATA_END - r_step)];

    always_comb begin
        pat      = pwfe_pkg::PAT_ZERO;
        use_pat  = 1'b0;
        n_parity = r_parity;
        n_byte   = 8'h00;
        if (r_step < pwfe_pkg::STEP_DATA) begin
            n_byte = pwfe_pkg::preamble_byte(r_step[2:0]);
        end else if (r_step <= pwfe_pkg::STEP_DATA_END) begin
            use_pat  = 1'b1;
            pat      = bit_val ? pwfe_pkg::PAT_ONE : pwfe_pkg::PAT_ZERO;
            n_parity = r_parity ^ bit_val;
        end else if (r_step == pwfe_pkg::STEP_PARITY) begin
            use_pat = 1'b1;
            pat     = r_parity ? pwfe_pkg::PAT_ZERO : pwfe_pkg::PAT_ONE;
        end else if (r_step == pwfe_pkg::STEP_TAIL) begin
            n_byte = {r_carry, pwfe_pkg::TAIL_NIB};
        end else begin
            n_byte = pwfe_pkg::stop_byte(3'(r_step - pwfe_pkg::STEP_STOP));
        end
        if (use_pat) begin
            n_byte  = {r_carry, pat[7:4]};
            n_carry = pat[3:0];
        end else begin
            n_carry = r_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_in_frame  <= 1'b0;
            r_step      <= pwfe_pkg::STEP_PREAMBLE;
            r_carry     <= pwfe_pkg::CARRY_RST;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_busy     <= 1'b1;
                r_in_frame <= 1'b1;
                if (open_new) begin
                    r_step   <= pwfe_pkg::STEP_PREAMBLE;
                    r_carry  <= pwfe_pkg::CARRY_RST;
                    r_parity <= 1'b0;
                end else begin
                    r_step <= pwfe_pkg::STEP_DATA;
                    if (fire) begin
                        r_carry  <= n_carry;
                        r_parity <= n_parity;
                    end
                end
            end else if (fire) begin
                r_step <= r_step + 1'b1;
                if (at_end) begin
                    r_busy <= 1'b0;
                end
                if (at_end && r_last) begin
                    r_carry    <= pwfe_pkg::CARRY_RST;
                    r_parity   <= 1'b0;
                    r_in_frame <= 1'b0;
                end else begin
                    r_carry  <= n_carry;
                    r_parity <= n_parity;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_in_item.data_byte;
            r_last <= i_in_item.last_byte;
        end
        if (fire) begin
            r_out.line_byte   <= n_byte;
            r_out.last_of_run <= at_end;
            r_out.frame_end   <= at_end && r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= pwfe_pkg::STEP_END)
        else $error("step counter beyond tail");

    a_busy_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_in_frame)
        else $error("item in flight outside a frame");

    a_frame_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.frame_end) |-> o_out_item.last_of_run)
        else $error("frame end without end of run");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !at_end) |-> !o_in_ready)
        else $error("input taken mid item");

    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !at_end) |=> r_step == $past(r_step) + 1'b1)
        else $error("step counter skipped");

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] PREAMBLE [6] = '{8'h00, 8'hFF, 8'hFF, 8'hFC, 8'hFF, 8'h83};
    localparam logic [7:0] STOP_TAIL [5] = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
    localparam int SETTLE_CYCLES = 6;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    pwfe_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    pwfe_pkg::t_out_item o_out_item;

    // encoder state for prediction
    logic                enc_in_frame;
    logic [3:0]          enc_carry;
    logic                enc_parity;
    pwfe_pkg::t_out_item line_q[$];
    pwfe_pkg::t_out_item want_line;

    int errors = 0;
    int bytes_sent = 0;
    int lines_checked = 0;
    int frames_closed = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    pulse_width_frame_encoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic void push_line(input logic [7:0] b);
        pwfe_pkg::t_out_item o;
        o.line_byte   = b;
        o.last_of_run = 1'b0;
        o.frame_end   = 1'b0;
        line_q.push_back(o);
    endfunction

    // half-byte delay through the carried nibble
    function automatic void push_unit(input logic [7:0] pat);
        push_line({enc_carry, pat[7:4]});
        enc_carry = pat[3:0];
    endfunction

    function automatic void encode_byte(input pwfe_pkg::t_in_item item);
        if (!enc_in_frame) begin
            foreach (PREAMBLE[k]) push_line(PREAMBLE[k]);
            enc_in_frame = 1'b1;
            enc_carry    = pwfe_pkg::CARRY_RST;
            enc_parity   = 1'b0;
        end
        for (int i = 7; i >= 0; i--) begin
            enc_parity ^= item.data_byte[i];
            push_unit(item.data_byte[i] ? pwfe_pkg::PAT_ONE : pwfe_pkg::PAT_ZERO);
        end
        if (item.last_byte) begin
            // odd parity over the whole frame
            push_unit(enc_parity ? pwfe_pkg::PAT_ZERO : pwfe_pkg::PAT_ONE);
            push_line({enc_carry, pwfe_pkg::TAIL_NIB});
            foreach (STOP_TAIL[k]) push_line(STOP_TAIL[k]);
            line_q[line_q.size()-1].frame_end = 1'b1;
            enc_in_frame = 1'b0;
            enc_carry    = pwfe_pkg::CARRY_RST;
            enc_parity   = 1'b0;
            frames_closed++;
        end
        line_q[line_q.size()-1].last_of_run = 1'b1;
    endfunction

    // receiver: random stalls, or a counted hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_q.size() == 0) begin
                $error("line_byte %h transferred with nothing expected", o_out_item.line_byte);
                errors++;
            end else begin
                want_line = line_q.pop_front();
                lines_checked++;
                if (o_out_item.line_byte !== want_line.line_byte) begin
                    $error("line_byte expected %h got %h",
                           want_line.line_byte, o_out_item.line_byte);
                    errors++;
                end
                if (o_out_item.last_of_run !== want_line.last_of_run) begin
                    $error("last_of_run expected %b got %b",
                           want_line.last_of_run, o_out_item.last_of_run);
                    errors++;
                end
                if (o_out_item.frame_end !== want_line.frame_end) begin
                    $error("frame_end expected %b got %b",
                           want_line.frame_end, o_out_item.frame_end);
                    errors++;
                end
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_item.data_byte <= data;
        i_in_item.last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        encode_byte('{data_byte: data, last_byte: last});
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (line_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_directed();
        logic [8:0] seq [14] = '{
            {8'h00, 1'b1}, {8'hFF, 1'b1}, {8'h01, 1'b1}, {8'hC3, 1'b1},
            {8'h80, 1'b0}, {8'h01, 1'b1},
            {8'hFE, 1'b0}, {8'h7F, 1'b0}, {8'hAA, 1'b0}, {8'h55, 1'b1},
            {8'h00, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0}, {8'hFF, 1'b1}
        };
        idle_pct  = 0;
        stall_pct = 0;
        foreach (seq[k]) send_byte(seq[k][8:1], seq[k][0]);
        wait_drained();
    endtask

    task automatic test_random_frames(input int count, input int idle, input int stall);
        int sent;
        int len;
        int sel;
        sent      = 0;
        idle_pct  = idle;
        stall_pct = stall;
        while (sent < count) begin
            sel = $urandom_range(99);
            if (sel < 80)
                len = $urandom_range(1, 4);
            else if (sel < 95)
                len = $urandom_range(5, 12);
            else
                len = $urandom_range(20, 30);
            for (int k = 0; k < len; k++) begin
                send_byte($urandom_range(255), k == len - 1);
                sent++;
            end
        end
        wait_drained();
    endtask

    // output held off while input keeps coming, so the block must stall its input
    task automatic test_full_stall();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 300;
        for (int k = 0; k < 12; k++) send_byte($urandom_range(255), k == 11);
        wait_drained();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_out_ready  = 1'b0;
        enc_in_frame = 1'b0;
        enc_carry    = pwfe_pkg::CARRY_RST;
        enc_parity   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_frames(90, 0, 0);
        test_random_frames(90, 58, 0);
        test_full_stall();
        test_random_frames(90, 0, 58);
        test_random_frames(90, 32, 32);

        $display("summary: %0d message bytes in %0d frames, %0d line bytes checked",
                 bytes_sent, frames_closed, lines_checked);
        $display("summary: idle sender, stalled receiver and a long output hold-off covered");
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// File: files.f
hdl/pwfe_pkg.sv
hdl/pulse_width_frame_encoder_top.sv
tb/testbench.sv
